// ----- hw/rtl/pbnp_pkg.sv -----
package pbnp_pkg;

  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LEARN = 2'd1,
    OP_PACK  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam int PAL_ENTRIES = 15;
  localparam int IDX_W       = 4;
  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;

  localparam logic [IDX_W-1:0] TRANSPARENT_IDX = 4'hF;

  // Channel scale: floor(c * 6666 / 10000), the divide done as a
  // multiply by ceil(2^35 / 10000) and a shift, exact for c * 6666 < 2^21.
  localparam int MUL_W = 22;
  localparam int PROD_W = 2 * MUL_W;
  localparam logic [MUL_W-1:0] SCALE_NUM   = 22'd6666;
  localparam logic [MUL_W-1:0] SCALE_RECIP = 22'd3435974;
  localparam int SCALE_SHIFT = 35;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

endpackage

// ----- hw/rtl/palette_builder_nibble_packer.sv -----
// Accept to result valid: clear goes to S_EMIT; learn and pack pass S_SEARCH (N filled
// entries scanned one per cycle by one 24-bit comparator; skipped if transparent), S_APPLY,
// S_EMIT. Read: three channels through one shared 22x22 multiplier, each via S_MUL, S_DIV,
// S_STORE; an entry past the filled ones goes to S_EMIT. One item at a time: the next is
// accepted after the result loads the output register (a first pack pixel gives no result).
// Reset (rst, synchronous) clears count, flag and pairing; stored palette colors are kept.
module palette_builder_nibble_packer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], entry_index[35:32], zero pad
  input  logic [pbnp_pkg::S_DATA_W-1:0]   s_tdata,
  // operation[1:0]
  input  logic [pbnp_pkg::OP_W-1:0]       s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // byte_out[7:0], color_count[11:8], too_many_colors[12], out_red[20:13],
  // out_green[28:21], out_blue[36:29], zero pad
  output logic [pbnp_pkg::M_DATA_W-1:0]   m_tdata,
  // kind[1:0]
  output logic [pbnp_pkg::OP_W-1:0]       m_tuser,
  output logic                            m_tlast
);
  import pbnp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_APPLY  = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_STORE  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;

  logic [COLOR_W-1:0] mem [PAL_ENTRIES];
  logic [COLOR_W-1:0] rd_data;

  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_valid;
  logic               found;
  logic [IDX_W-1:0]   pos;
  op_t                op_q;
  logic [COLOR_W-1:0] rgb_q;
  logic               transp_q;
  logic               eog_q;
  logic [IDX_W-1:0]   count;
  logic               ovf;
  logic [IDX_W-1:0]   held;
  logic               odd;
  logic [1:0]         ch;
  logic [PROD_W-1:0]  prod;
  logic [CHAN_W-1:0]  scaled [3];
  logic [7:0]         byte_res;
  logic               last_res;

  logic               accept;
  op_t                in_op;
  logic [IDX_W-1:0]   in_sel;
  logic               in_transp;
  logic               hit;
  logic               issue;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               learn_new;
  logic               wr_en;
  logic [IDX_W-1:0]   pack_idx;
  logic [CHAN_W-1:0]  chan;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic               emit_load;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign in_op     = op_t'(s_tuser);
  assign in_sel    = s_tdata[35:32];
  assign in_transp = (s_tdata[31:24] == 8'd0);

  // Compare the entry fetched last cycle while the next one is fetched.
  assign hit   = chk_valid && (rd_data == rgb_q);
  assign issue = (state == S_SEARCH) && !hit && (idx < count);
  assign rd_en = (accept && (in_op == OP_READ)) || issue;
  assign rd_addr = (state == S_IDLE) ? in_sel : idx;

  assign learn_new = (op_q == OP_LEARN) && !transp_q && !found;
  assign wr_en     = (state == S_APPLY) && learn_new && (count < IDX_W'(PAL_ENTRIES));
  assign pack_idx  = transp_q ? TRANSPARENT_IDX : (found ? pos : '0);

  always_comb begin
    case (ch)
      2'd0:    chan = rd_data[23:16];
      2'd1:    chan = rd_data[15:8];
      default: chan = rd_data[7:0];
    endcase
  end

  always_comb begin
    if (state == S_DIV) begin
      mul_a = prod[MUL_W-1:0];
      mul_b = SCALE_RECIP;
    end else begin
      mul_a = {{(MUL_W-CHAN_W){1'b0}}, chan};
      mul_b = SCALE_NUM;
    end
  end

  assign emit_load = (state == S_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count] <= rgb_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL || state == S_DIV) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      held      <= '0;
      odd       <= 1'b0;
      chk_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= in_op;
            rgb_q     <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
            transp_q  <= in_transp;
            eog_q     <= s_tlast;
            idx       <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
            pos       <= '0;
            ch        <= '0;
            byte_res  <= '0;
            last_res  <= 1'b0;
            scaled[0] <= '0;
            scaled[1] <= '0;
            scaled[2] <= '0;
            case (in_op)
              OP_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
                held  <= '0;
                odd   <= 1'b0;
                state <= S_EMIT;
              end
              OP_LEARN, OP_PACK: begin
                state <= in_transp ? S_APPLY : S_SEARCH;
              end
              OP_READ: begin
                state <= (in_sel < count) ? S_MUL : S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          chk_valid <= issue;
          if (hit) begin
            found <= 1'b1;
            pos   <= chk_idx;
            state <= S_APPLY;
          end else if (issue) begin
            chk_idx <= idx;
            idx     <= idx + 1'b1;
          end else begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          chk_valid <= 1'b0;
          if (op_q == OP_LEARN) begin
            if (learn_new) begin
              if (count < IDX_W'(PAL_ENTRIES)) begin
                count <= count + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
            end
            state <= S_EMIT;
          end else if (!odd && !eog_q) begin
            // first of a pair: hold it, no result
            held  <= pack_idx;
            odd   <= 1'b1;
            state <= S_IDLE;
          end else begin
            byte_res <= odd ? {held, pack_idx} : {pack_idx, 4'd0};
            last_res <= eog_q;
            held     <= '0;
            odd      <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_STORE;
        end
        S_STORE: begin
          scaled[ch] <= prod[SCALE_SHIFT +: CHAN_W];
          if (ch == 2'd2) begin
            state <= S_EMIT;
          end else begin
            ch    <= ch + 1'b1;
            state <= S_MUL;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload of the output register; loaded only with a new result.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {3'd0, scaled[2], scaled[1], scaled[0], ovf, count, byte_res};
      m_tuser <= op_q;
      m_tlast <= last_res;
    end
  end

endmodule

// ----- hw/rtl/pbnp_checker.sv -----
module pbnp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [pbnp_pkg::S_DATA_W-1:0] s_tdata,
  input logic [pbnp_pkg::OP_W-1:0]     s_tuser,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pbnp_pkg::M_DATA_W-1:0] m_tdata,
  input logic [pbnp_pkg::OP_W-1:0]     m_tuser,
  input logic                          m_tlast
);
  import pbnp_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // One item at a time: input closes right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == OP_CLEAR) |-> (m_tdata[12:0] == 13'd0) && !m_tlast)
    else $error("clear result carries count, flag or byte");

  a_pack_only_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != OP_PACK) |-> (m_tdata[7:0] == 8'd0) && !m_tlast)
    else $error("byte or last set outside pack");

  a_read_only_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != OP_READ) |-> (m_tdata[39:13] == 27'd0))
    else $error("color set outside read");

endmodule

bind palette_builder_nibble_packer pbnp_checker u_pbnp_checker (.*);

// ----- tb/tb_palette_builder_nibble_packer.sv -----
`timescale 1ns / 1ps

module tb_palette_builder_nibble_packer;
  import pbnp_pkg::*;

  typedef struct packed {
    op_t               kind;
    logic [7:0]        packed_byte;
    logic              last_byte;
    logic [IDX_W-1:0]  color_count;
    logic              too_many;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } palette_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0]     s_tuser = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [OP_W-1:0]     m_tuser;
  logic                m_tlast;

  // Predictor state
  logic [COLOR_W-1:0]  palette_mirror [PAL_ENTRIES];
  logic [IDX_W-1:0]    filled_mirror = '0;
  logic                overflow_mirror = 1'b0;
  logic [IDX_W-1:0]    held_mirror = '0;
  logic                odd_mirror = 1'b0;

  palette_result_t     expected_results [$];
  palette_result_t     want;
  palette_result_t     got;
  int                  mismatches = 0;
  int                  items_sent = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  palette_builder_nibble_packer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic find_entry(input logic [COLOR_W-1:0] rgb,
                                      output logic [IDX_W-1:0] pos);
    pos = '0;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      if (i < filled_mirror && palette_mirror[i] == rgb) begin
        pos = IDX_W'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [CHAN_W-1:0] panel_scale(input logic [CHAN_W-1:0] c);
    int unsigned prod;
    prod = int'(c) * 6666;
    return CHAN_W'(prod / 10000);
  endfunction

  task automatic predict_item(input op_t op, input logic [COLOR_W-1:0] rgb,
                              input logic [7:0] alpha, input logic eog,
                              input logic [IDX_W-1:0] sel);
    palette_result_t  res;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] nib;
    logic             hit;
    logic [COLOR_W-1:0] c;
    res = '0;
    res.kind = op;
    case (op)
      OP_CLEAR: begin
        filled_mirror = '0;
        overflow_mirror = 1'b0;
        held_mirror = '0;
        odd_mirror = 1'b0;
      end
      OP_LEARN: begin
        hit = find_entry(rgb, pos);
        if (alpha != 0 && !hit) begin
          if (filled_mirror < PAL_ENTRIES) begin
            palette_mirror[filled_mirror] = rgb;
            filled_mirror = filled_mirror + 1'b1;
          end else begin
            overflow_mirror = 1'b1;
          end
        end
      end
      OP_PACK: begin
        hit = find_entry(rgb, pos);
        if (alpha == 0) nib = TRANSPARENT_IDX;
        else if (hit) nib = pos;
        else nib = '0;
        if (!odd_mirror) begin
          if (!eog) begin
            // first of a pair: hold, no item comes out
            held_mirror = nib;
            odd_mirror = 1'b1;
            return;
          end
          res.packed_byte = {nib, 4'h0};
        end else begin
          res.packed_byte = {held_mirror, nib};
          odd_mirror = 1'b0;
        end
        held_mirror = '0;
        res.last_byte = eog;
      end
      default: begin
        if (sel < filled_mirror) begin
          c = palette_mirror[sel];
          res.red = panel_scale(c[23:16]);
          res.green = panel_scale(c[15:8]);
          res.blue = panel_scale(c[7:0]);
        end
      end
    endcase
    res.color_count = filled_mirror;
    res.too_many = overflow_mirror;
    expected_results = {expected_results, res};
  endtask

  // Called right after the clock rises; leaves tvalid high after the accept.
  task automatic send_item(input op_t op, input logic [COLOR_W-1:0] rgb,
                           input logic [7:0] alpha, input logic eog,
                           input logic [IDX_W-1:0] sel);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tlast <= eog;
    s_tdata <= {4'h0, sel, alpha, rgb[7:0], rgb[15:8], rgb[23:16]};
    do @(posedge clk); while (!s_tready);
    predict_item(op, rgb, alpha, eog, sel);
    items_sent++;
  endtask

  // Hold the sender until every expected item is back and the block is quiet.
  task automatic drain_results();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [COLOR_W-1:0] random_color();
    case ($urandom_range(9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_alpha();
    if ($urandom_range(99) < 15) return 8'h00;
    return 8'($urandom_range(255, 1));
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.kind = op_t'(m_tuser);
      got.packed_byte = m_tdata[7:0];
      got.last_byte = m_tlast;
      got.color_count = m_tdata[11:8];
      got.too_many = m_tdata[12];
      got.red = m_tdata[20:13];
      got.green = m_tdata[28:21];
      got.blue = m_tdata[36:29];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: kind=%0d byte=%h last=%b cnt=%0d flag=%b rgb=%0d,%0d,%0d",
                   got.kind, got.packed_byte, got.last_byte, got.color_count,
                   got.too_many, got.red, got.green, got.blue);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("exp: kind=%0d byte=%h last=%b cnt=%0d flag=%b rgb=%0d,%0d,%0d",
                     want.kind, want.packed_byte, want.last_byte, want.color_count,
                     want.too_many, want.red, want.green, want.blue);
            $display("got: kind=%0d byte=%h last=%b cnt=%0d flag=%b rgb=%0d,%0d,%0d",
                     got.kind, got.packed_byte, got.last_byte, got.color_count,
                     got.too_many, got.red, got.green, got.blue);
          end
        end
      end
    end
  end

  task automatic test_learn_and_read();
    send_item(OP_CLEAR, 24'h0, 8'h0, 1'b0, 4'h0);
    send_item(OP_LEARN, 24'h000000, 8'hFF, 1'b0, 4'h0);
    send_item(OP_LEARN, 24'hFFFFFF, 8'h01, 1'b0, 4'h0);
    send_item(OP_LEARN, 24'hFFFFFF, 8'h80, 1'b0, 4'h0);  // already known
    send_item(OP_LEARN, 24'h123456, 8'h00, 1'b0, 4'h0);  // transparent, ignored
    send_item(OP_LEARN, 24'hA5C3E7, 8'hFF, 1'b1, 4'hF);
    send_item(OP_READ, 24'h0, 8'h0, 1'b0, 4'h0);
    send_item(OP_READ, 24'h0, 8'h0, 1'b0, 4'h1);
    send_item(OP_READ, 24'hFFFFFF, 8'hFF, 1'b1, 4'h2);
    send_item(OP_READ, 24'h0, 8'h0, 1'b0, 4'h3);   // past the filled entries
    send_item(OP_READ, 24'h0, 8'h0, 1'b0, 4'hF);
  endtask

  task automatic test_pack_pairing();
    send_item(OP_PACK, 24'hFFFFFF, 8'hFF, 1'b0, 4'h0);
    send_item(OP_PACK, 24'h123456, 8'h00, 1'b0, 4'h0);
    send_item(OP_PACK, 24'h5A5A5A, 8'hFF, 1'b1, 4'h0);  // lone pixel flushed
    send_item(OP_PACK, 24'hA5C3E7, 8'h7F, 1'b0, 4'h0);
    send_item(OP_PACK, 24'h000000, 8'hFF, 1'b1, 4'h0);
    send_item(OP_CLEAR, 24'hFFFFFF, 8'hFF, 1'b1, 4'hF);
    // white must not match entries that were never filled
    send_item(OP_PACK, 24'hFFFFFF, 8'hFF, 1'b1, 4'h0);
  endtask

  // One graphic: sometimes random items first, usually a clear, then learn colors (often
  // past the palette size), read some entries back, then pack pixels ending on end_of_graphic.
  task automatic run_graphic();
    logic [COLOR_W-1:0] seen [$];
    logic [COLOR_W-1:0] rgb;
    logic [7:0]         alpha;
    int                 n_learn;
    int                 n_pack;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(3, 1))
        send_item(op_t'($urandom_range(3)), COLOR_W'($urandom), 8'($urandom),
                  1'($urandom), 4'($urandom));
    end
    if ($urandom_range(99) < 85)
      send_item(OP_CLEAR, COLOR_W'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
    n_learn = $urandom_range(20);
    repeat (n_learn) begin
      if (seen.size() != 0 && $urandom_range(99) < 30)
        rgb = seen[$urandom_range(seen.size() - 1)];
      else
        rgb = random_color();
      alpha = random_alpha();
      if (alpha != 0) seen = {seen, rgb};
      send_item(OP_LEARN, rgb, alpha, 1'($urandom), 4'($urandom));
    end
    repeat ($urandom_range(4))
      send_item(OP_READ, COLOR_W'($urandom), 8'($urandom), 1'($urandom),
                4'($urandom_range(15)));
    n_pack = $urandom_range(24, 1);
    for (int i = 0; i < n_pack; i++) begin
      if (seen.size() != 0 && $urandom_range(99) < 70)
        rgb = seen[$urandom_range(seen.size() - 1)];
      else
        rgb = random_color();
      send_item(OP_PACK, rgb, random_alpha(),
                (i == n_pack - 1) || ($urandom_range(99) < 8), 4'($urandom));
    end
  endtask

  task automatic test_random_graphics(input int idle_pct, input int stall_pct,
                                      input int n_items);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) run_graphic();
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_learn_and_read();
    test_pack_pairing();
    drain_results();
    test_random_graphics(0, 0, 450);
    test_random_graphics(45, 0, 450);
    test_random_graphics(0, 45, 450);
    test_random_graphics(15, 15, 450);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("palette_builder_nibble_packer: match");
    end else begin
      $display("palette_builder_nibble_packer: mismatch");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("palette_builder_nibble_packer: mismatch");
    $finish;
  end

endmodule
